>>> rtl/slseq_pkg.sv
// Shared types, codes and reset values for the scanline sequencer with palette.
// Used by scanline_sequencer_palette_top and its port checker.
package slseq_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF   = 256;
    localparam int unsigned LINE_REPEAT_SHIFT_DEF = 1;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam int unsigned LINE_W  = 11;
    localparam int unsigned ROW_W   = 10;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned WORD_W  = 32;

    localparam logic [7:0]  FRONT_PORCH_RST = 8'd12;
    localparam logic [7:0]  SYNC_RST        = 8'd2;
    localparam logic [7:0]  BACK_PORCH_RST  = 8'd35;
    localparam logic [10:0] ACTIVE_RST      = 11'd400;
    localparam logic [1:0]  NO_SLOT         = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PAL_WRITE = 2'd1,
        OP_PIXEL     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_VSYNC  = 2'd0,
        KIND_BLANK  = 2'd1,
        KIND_ACTIVE = 2'd2,
        KIND_PIXEL  = 2'd3
    } line_kind_t;

    typedef enum logic [2:0] {
        CFG_FRONT_PORCH = 3'd0,
        CFG_SYNC        = 3'd1,
        CFG_BACK_PORCH  = 3'd2,
        CFG_ACTIVE      = 3'd3,
        CFG_ENABLE      = 3'd4
    } cfg_reg_t;

endpackage

>>> rtl/scanline_sequencer_palette_top.sv
// Top level of the scanline sequencer: vertical line timing plus a palette memory.
// Depends on slseq_pkg.
//
// One word is taken every clock while the input is not stalled. A palette write goes into
// the palette memory at the edge where it is accepted. A pixel lookup reads the memory at
// that same edge, and its result is formed in the following cycle and loaded into the
// output register when the second stage advances. The result is offered from the output
// register and held there until it is taken. A line tick is classified and the scanline
// counter advanced in that second stage too. Sustained rate is one word per clock while
// the output is not stalled. The input stalls only when a result waits in the output
// register and the stage behind it is also full. Words that give no result (palette
// writes, op 3) leave nothing on the output. The palette has no reset and no clearing
// pass: an entry must be written before it is looked up.
module scanline_sequencer_palette_top #(
    parameter int unsigned PALETTE_ENTRIES   = slseq_pkg::PALETTE_ENTRIES_DEF,
    parameter int unsigned LINE_REPEAT_SHIFT = slseq_pkg::LINE_REPEAT_SHIFT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // palette_index[7:0], comp_high[13:8], comp_mid[19:14], comp_low[25:20],
    // pixel_code[33:26], zero fill [39:34]
    input  logic [slseq_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // source_row[9:0], line_slot[10], refill[11], pixel_word[43:12], zero fill [47:44]
    output logic [slseq_pkg::M_TDATA_W-1:0]    m_tdata,
    // line_kind[1:0]
    output logic [1:0]                         m_tuser,
    // frame_end
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [slseq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [slseq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [slseq_pkg::COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];

    logic [7:0]  front_porch_reg, sync_reg, back_porch_reg;
    logic [10:0] active_reg;
    logic        enable_reg;

    logic [slseq_pkg::LINE_W-1:0] scanline_reg, scanline_next;
    logic [1:0]                   last_slot_reg, last_slot_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_pixel_reg;
    logic                          s1_hit_reg;
    logic [slseq_pkg::COLOR_W-1:0] rd_data_reg;

    logic                           m_valid_reg, m_valid_next;
    logic [1:0]                     m_kind_reg, m_kind_next;
    logic [slseq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    logic [7:0]  in_index;
    logic [5:0]  in_high, in_mid, in_low;
    logic [7:0]  in_code;
    logic        accept, advance, s1_load;
    logic        idx_hit, code_hit;

    logic [8:0]                   sync_stop;
    logic [9:0]                   inactive;
    logic [11:0]                  total;
    logic [slseq_pkg::LINE_W-1:0] line_diff, row_full;
    logic [11:0]                  line_inc;
    logic                         in_vsync, in_blank, wrap;
    logic [slseq_pkg::ROW_W-1:0]  row;
    logic                         slot, refill;
    logic [slseq_pkg::WORD_W-1:0] pixel_word;

    assign in_index = s_tdata[7:0];
    assign in_high  = s_tdata[13:8];
    assign in_mid   = s_tdata[19:14];
    assign in_low   = s_tdata[25:20];
    assign in_code  = s_tdata[33:26];

    assign idx_hit  = {1'b0, in_index} < 9'(PALETTE_ENTRIES);
    assign code_hit = {1'b0, in_code} < 9'(PALETTE_ENTRIES);

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign s1_load  = accept && (s_tuser == slseq_pkg::OP_TICK || s_tuser == slseq_pkg::OP_PIXEL);

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == slseq_pkg::OP_PAL_WRITE && idx_hit) begin
            palette_mem[in_index[IDX_W-1:0]] <= {in_high[5:1], in_mid, in_low[5:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg  <= palette_mem[in_code[IDX_W-1:0]];
            s1_pixel_reg <= (s_tuser == slseq_pkg::OP_PIXEL);
            s1_hit_reg   <= code_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_porch_reg <= slseq_pkg::FRONT_PORCH_RST;
            sync_reg        <= slseq_pkg::SYNC_RST;
            back_porch_reg  <= slseq_pkg::BACK_PORCH_RST;
            active_reg      <= slseq_pkg::ACTIVE_RST;
            enable_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                slseq_pkg::CFG_FRONT_PORCH: front_porch_reg <= cfg_wdata[7:0];
                slseq_pkg::CFG_SYNC:        sync_reg        <= cfg_wdata[7:0];
                slseq_pkg::CFG_BACK_PORCH:  back_porch_reg  <= cfg_wdata[7:0];
                slseq_pkg::CFG_ACTIVE:      active_reg      <= cfg_wdata[10:0];
                slseq_pkg::CFG_ENABLE:      enable_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign sync_stop = {1'b0, front_porch_reg} + {1'b0, sync_reg};
    assign inactive  = {1'b0, sync_stop} + {2'b00, back_porch_reg};
    assign total     = {2'b00, inactive} + {1'b0, active_reg};
    assign line_diff = scanline_reg - {1'b0, inactive};
    assign row_full  = line_diff >> LINE_REPEAT_SHIFT;
    assign row       = row_full[slseq_pkg::ROW_W-1:0];
    assign slot      = row_full[0];
    assign line_inc  = {1'b0, scanline_reg} + 12'd1;
    assign in_vsync  = scanline_reg >= {3'b000, front_porch_reg}
                       && scanline_reg < {2'b00, sync_stop};
    assign in_blank  = scanline_reg < {1'b0, inactive};
    assign wrap      = line_inc >= total || line_inc[11];
    assign refill    = {1'b0, slot} != last_slot_reg;
    assign pixel_word = (enable_reg && s1_hit_reg) ? {rd_data_reg, rd_data_reg}
                                                   : '0;

    always_comb begin
        scanline_next  = scanline_reg;
        last_slot_next = last_slot_reg;
        m_kind_next    = m_kind_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        if (advance) begin
            m_data_next = '0;
            m_last_next = 1'b0;
            if (s1_pixel_reg) begin
                m_kind_next        = slseq_pkg::KIND_PIXEL;
                m_data_next[43:12] = pixel_word;
            end else begin
                if (in_vsync) begin
                    m_kind_next = slseq_pkg::KIND_VSYNC;
                end else if (in_blank) begin
                    m_kind_next = slseq_pkg::KIND_BLANK;
                end else begin
                    m_kind_next      = slseq_pkg::KIND_ACTIVE;
                    m_data_next[9:0] = row;
                    m_data_next[10]  = slot;
                    m_data_next[11]  = refill;
                    last_slot_next   = {1'b0, slot};
                end
                if (wrap) begin
                    scanline_next  = '0;
                    last_slot_next = slseq_pkg::NO_SLOT;
                    m_last_next    = 1'b1;
                end else begin
                    scanline_next = line_inc[slseq_pkg::LINE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scanline_reg  <= '0;
            last_slot_reg <= slseq_pkg::NO_SLOT;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            scanline_reg  <= scanline_next;
            last_slot_reg <= last_slot_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/slseq_checker.sv
// Port-level checks for scanline_sequencer_palette_top, attached by bind.
// Depends on slseq_pkg.
module slseq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [slseq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pixel_no_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == slseq_pkg::KIND_PIXEL |-> !m_tlast && m_tdata[11:0] == 12'd0)
        else $error("pixel word carries line fields");

    a_line_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != slseq_pkg::KIND_PIXEL |-> m_tdata[47:12] == 36'd0)
        else $error("line word carries pixel data");

    a_blank_no_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == slseq_pkg::KIND_VSYNC || m_tuser == slseq_pkg::KIND_BLANK)
        |-> m_tdata[11:0] == 12'd0)
        else $error("blank line carries row fields");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind scanline_sequencer_palette_top slseq_checker u_slseq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
